// ===== src/wep_pkg.sv =====
// Shared types, constants and helpers for the wireframe edge projector.
// No dependencies; imported by wep_div, wireframe_edge_projector, wep_checker and the testbench.
package wep_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int VP_DEPTH       = 16;
   localparam int MT_DEPTH       = 12;
   localparam int ELEM_W         = 4;
   localparam int ACC_W          = 50;
   localparam int DVD_W          = 48;
   localparam int SCL_W          = 49;
   localparam int FRAC_W         = 16;

   localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // identity diagonal of the 3x4 model transform
   localparam logic [ELEM_W-1:0] MT_DIAG0 = 4'd0;
   localparam logic [ELEM_W-1:0] MT_DIAG1 = 4'd5;
   localparam logic [ELEM_W-1:0] MT_DIAG2 = 4'd10;
   localparam logic [ELEM_W-1:0] MT_LAST  = 4'd11;
   localparam logic [ELEM_W-1:0] VP_LAST  = 4'd15;

   localparam logic [13:0] WIDTH_RST  = 14'd1920;
   localparam logic [13:0] HEIGHT_RST = 14'd1080;
   localparam logic [15:0] THICK_RST  = 16'd256;

   typedef enum logic [1:0] {
      OP_LOAD_VP = 2'd0,
      OP_LOAD_MT = 2'd1,
      OP_LOAD_PT = 2'd2,
      OP_EDGE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_THICK  = 2'd2
   } csr_type;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_PREAD = 10'b00_0000_0010,
      S_MAT   = 10'b00_0000_0100,
      S_PWR   = 10'b00_0000_1000,
      S_CHECK = 10'b00_0001_0000,
      S_DIVST = 10'b00_0010_0000,
      S_DIV   = 10'b00_0100_0000,
      S_SCL1  = 10'b00_1000_0000,
      S_SCL2  = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic all_same;
      all_same = (v[ACC_W-1:31] == '0) || (v[ACC_W-1:31] == '1);
      if (all_same) begin
         return v[31:0];
      end else if (v[ACC_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

endpackage

// ===== src/wep_div.sv =====
// Bit-serial signed divider: sat32((num * 2^16) / den), truncating toward zero.
// Depends on wep_pkg. One quotient bit per cycle; a zero divisor saturates to the sign of num (zero num gives zero).
module wep_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               busy,
   output logic               done,
   output logic signed [31:0] quo
);
   import wep_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [5:0]        cnt_ff;
   logic [32:0]       rem_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DVD_W-1:0]  q_ff;
   logic [31:0]       dmag_ff;
   logic              neg_ff;
   logic signed [31:0] quo_ff;

   logic [32:0]       rem_sh;
   logic              qbit;
   logic [32:0]       rem_in;
   logic [DVD_W-1:0]  q_in;
   logic [31:0]       num_mag;
   logic [31:0]       den_mag;
   logic signed [31:0] fin;

   assign num_mag = num[31] ? 32'(-num) : num;
   assign den_mag = den[31] ? 32'(-den) : den;

   assign rem_sh = {rem_ff[31:0], dvd_ff[DVD_W-1]};
   assign qbit   = (rem_sh >= {1'b0, dmag_ff});
   assign rem_in = qbit ? (rem_sh - {1'b0, dmag_ff}) : rem_sh;
   assign q_in   = {q_ff[DVD_W-2:0], qbit};

   always_comb begin
      if (!neg_ff) begin
         fin = (q_in > DVD_W'(SAT_MAX)) ? SAT_MAX : q_in[31:0];
      end else begin
         fin = (q_in > DVD_W'(33'h1_0000_0000 >> 1)) ? SAT_MIN : 32'(-q_in[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (den == '0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         q_ff    <= '0;
         dvd_ff  <= {num_mag, 16'b0};
         dmag_ff <= den_mag;
         neg_ff  <= num[31] ^ den[31];
         if (num[31]) begin
            quo_ff <= SAT_MIN;
         end else if (num != '0) begin
            quo_ff <= SAT_MAX;
         end else begin
            quo_ff <= '0;
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         if (cnt_ff == 6'(DVD_W - 1)) begin
            quo_ff <= fin;
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== src/wireframe_edge_projector.sv =====
// Top level of the wireframe edge projector: matrix/point memories, sequencer,
// shared multiply-accumulate pipeline and screen scaling. Depends on wep_pkg, wep_div.
//
// Matrix-element loads are written as the request is taken. A point load runs its 12
// model-transform elements through the single 32x32 multiply-accumulate pipeline and
// writes the point memory. An edge reads each endpoint from the point memory, streams
// the 16 view-projection elements through the same pipeline and then divides clip x
// and y by w in the bit-serial divider; an edge that draws spends most of its time in
// its four divides, and one whose start lies behind the camera ends without dividing.
// The finished line sits in an output register, so the next item is taken while
// it waits on rsp_stall. Matrices read as their reset values until written.
module wireframe_edge_projector #(
   parameter int MAX_POINTS = wep_pkg::MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_first_index,
   input  logic [5:0]         req_second_index,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   input  logic [31:0]        req_edge_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_start_x,
   output logic signed [31:0] rsp_start_y,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   output logic [31:0]        rsp_line_color,
   output logic [16:0]        rsp_line_thickness,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);
   import wep_pkg::*;

   localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   // configuration
   logic [13:0] width_ff, height_ff;
   logic [15:0] thick_ff;

   // memories
   logic signed [31:0] vp_mem [VP_DEPTH];
   logic signed [31:0] mt_mem [MT_DEPTH];
   logic [95:0]        pt_mem [MAX_POINTS];
   logic [VP_DEPTH-1:0] vp_vld_ff;
   logic [MT_DEPTH-1:0] mt_vld_ff;
   logic signed [31:0] vp_rd_ff, mt_rd_ff;
   logic [95:0]        pt_rd_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic               edge_ff;
   logic               side_ff;
   logic               axis_ff;
   logic [PIDX_W-1:0]  idx_a_ff, idx_b_ff;
   logic [31:0]        color_ff;
   logic signed [31:0] pld_vec_ff [3];

   // multiply-accumulate pipeline
   logic               iss_on_ff;
   logic [ELEM_W-1:0]  iss_k_ff;
   logic               s1_vld_ff, s1_ok_ff;
   logic [ELEM_W-1:0]  s1_k_ff;
   logic               s2_vld_ff;
   logic [ELEM_W-1:0]  s2_k_ff;
   logic signed [ACC_W-1:0] term_ff, acc_ff, acc_in;
   logic signed [31:0] res_ff [4];
   logic [ELEM_W-1:0]  last_k;
   logic signed [31:0] mat_val, vec_sel;
   logic signed [63:0] prod;
   logic               mat_done;

   // divide and scale
   logic               div_start, div_busy, div_done;
   logic signed [31:0] div_quo;
   logic signed [33:0] scl_sum;
   logic [13:0]        scl_size;
   logic signed [SCL_W-1:0] scl_prod_ff;
   logic signed [31:0] scr_ff [4];

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;
   logic [31:0]        out_color_ff;
   logic [16:0]        out_thick_ff;

   logic               req_xfer;
   op_type             op;
   logic               a_ok, b_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign op        = op_type'(req_op);
   assign a_ok      = (int'(req_first_index) < MAX_POINTS);
   assign b_ok      = (int'(req_second_index) < MAX_POINTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thick_ff  <= THICK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_wr_data[13:0];
            CSR_HEIGHT: height_ff <= csr_wr_data[13:0];
            CSR_THICK:  thick_ff  <= csr_wr_data;
            default:    ;
         endcase
      end
   end

   // matrix element writes; valid bits stand in for the reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_vld_ff <= '0;
         mt_vld_ff <= '0;
      end else if (req_xfer) begin
         if (op == OP_LOAD_VP && req_first_index < 6'(VP_DEPTH)) begin
            vp_vld_ff[req_first_index[ELEM_W-1:0]] <= 1'b1;
         end
         if (op == OP_LOAD_MT && req_first_index < 6'(MT_DEPTH)) begin
            mt_vld_ff[req_first_index[ELEM_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && op == OP_LOAD_VP && req_first_index < 6'(VP_DEPTH)) begin
         vp_mem[req_first_index[ELEM_W-1:0]] <= req_value_x;
      end
      if (req_xfer && op == OP_LOAD_MT && req_first_index < 6'(MT_DEPTH)) begin
         mt_mem[req_first_index[ELEM_W-1:0]] <= req_value_x;
      end
      if (iss_on_ff) begin
         vp_rd_ff <= vp_mem[iss_k_ff];
         if (iss_k_ff < ELEM_W'(MT_DEPTH)) begin
            mt_rd_ff <= mt_mem[iss_k_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PWR) begin
         pt_mem[idx_a_ff] <= {res_ff[2], res_ff[1], res_ff[0]};
      end
      if (state_ff == S_PREAD) begin
         pt_rd_ff <= pt_mem[side_ff ? idx_b_ff : idx_a_ff];
      end
   end

   // pipeline: issue read, select value, multiply, accumulate
   assign last_k = edge_ff ? VP_LAST : MT_LAST;

   always_comb begin
      if (s1_ok_ff) begin
         mat_val = edge_ff ? vp_rd_ff : mt_rd_ff;
      end else if (!edge_ff && (s1_k_ff == MT_DIAG0 || s1_k_ff == MT_DIAG1
                                || s1_k_ff == MT_DIAG2)) begin
         mat_val = ONE_Q16;
      end else begin
         mat_val = '0;
      end
   end

   always_comb begin
      unique case (s1_k_ff[1:0])
         2'd0:    vec_sel = edge_ff ? pt_rd_ff[31:0]  : pld_vec_ff[0];
         2'd1:    vec_sel = edge_ff ? pt_rd_ff[63:32] : pld_vec_ff[1];
         2'd2:    vec_sel = edge_ff ? pt_rd_ff[95:64] : pld_vec_ff[2];
         default: vec_sel = '0;
      endcase
   end

   assign prod   = 64'(mat_val) * 64'(vec_sel);
   assign acc_in = ((s2_k_ff[1:0] == 2'd0) ? '0 : acc_ff) + term_ff;
   assign mat_done = s2_vld_ff && (s2_k_ff == last_k);

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_on_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if ((state_ff == S_IDLE && req_xfer && op == OP_LOAD_PT && a_ok)
             || state_ff == S_PREAD) begin
            iss_on_ff <= 1'b1;
         end else if (iss_on_ff && iss_k_ff == last_k) begin
            iss_on_ff <= 1'b0;
         end
         s1_vld_ff <= iss_on_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!iss_on_ff) begin
         iss_k_ff <= '0;
      end else begin
         iss_k_ff <= iss_k_ff + ELEM_W'(1);
      end
      s1_k_ff  <= iss_k_ff;
      s1_ok_ff <= edge_ff ? vp_vld_ff[iss_k_ff]
                          : (iss_k_ff < ELEM_W'(MT_DEPTH)) && mt_vld_ff[iss_k_ff];
      s2_k_ff  <= s1_k_ff;
      if (s1_k_ff[1:0] == 2'd3) begin
         term_ff <= ACC_W'(mat_val);
      end else begin
         term_ff <= ACC_W'(prod >>> FRAC_W);
      end
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
         if (s2_k_ff[1:0] == 2'd3) begin
            res_ff[s2_k_ff[3:2]] <= sat32(acc_in);
         end
      end
   end

   // divide and screen scaling
   assign div_start = (state_ff == S_DIVST);

   wep_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (axis_ff ? res_ff[1] : res_ff[0]),
      .den   (res_ff[3]),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign scl_size = axis_ff ? height_ff : width_ff;
   assign scl_sum  = (axis_ff ? -34'(div_quo) : 34'(div_quo)) + 34'(ONE_Q16);

   always_ff @(posedge clock) begin
      if (state_ff == S_SCL1) begin
         scl_prod_ff <= SCL_W'(scl_sum) * SCL_W'({1'b0, scl_size});
      end
      if (state_ff == S_SCL2) begin
         scr_ff[{side_ff, axis_ff}] <= sat32(ACC_W'(scl_prod_ff >>> 1));
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (op == OP_LOAD_PT && a_ok) begin
                  state_in = S_MAT;
               end else if (op == OP_EDGE && a_ok && b_ok) begin
                  state_in = S_PREAD;
               end
            end
         end
         S_PREAD: state_in = S_MAT;
         S_MAT: begin
            if (mat_done) begin
               state_in = edge_ff ? S_CHECK : S_PWR;
            end
         end
         S_PWR:   state_in = S_IDLE;
         S_CHECK: state_in = res_ff[2][31] ? S_IDLE : S_DIVST;
         S_DIVST: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_SCL1;
            end
         end
         S_SCL1:  state_in = S_SCL2;
         S_SCL2: begin
            priority if (!axis_ff) begin
               state_in = S_DIVST;
            end else if (!side_ff) begin
               state_in = S_PREAD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         edge_ff  <= 1'b0;
         side_ff  <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_xfer) begin
            edge_ff <= (op == OP_EDGE);
            side_ff <= 1'b0;
            axis_ff <= 1'b0;
         end else if (state_ff == S_SCL2) begin
            axis_ff <= ~axis_ff;
            if (axis_ff) begin
               side_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_xfer) begin
         idx_a_ff      <= PIDX_W'(req_first_index);
         idx_b_ff      <= PIDX_W'(req_second_index);
         color_ff      <= req_edge_color;
         pld_vec_ff[0] <= req_value_x;
         pld_vec_ff[1] <= req_value_y;
         pld_vec_ff[2] <= req_value_z;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         out_sx_ff    <= scr_ff[0];
         out_sy_ff    <= scr_ff[1];
         out_ex_ff    <= scr_ff[2];
         out_ey_ff    <= scr_ff[3];
         out_color_ff <= color_ff;
         out_thick_ff <= {thick_ff, 1'b0};
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_start_x        = out_sx_ff;
   assign rsp_start_y        = out_sy_ff;
   assign rsp_end_x          = out_ex_ff;
   assign rsp_end_y          = out_ey_ff;
   assign rsp_line_color     = out_color_ff;
   assign rsp_line_thickness = out_thick_ff;

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == S_DIV))
      else $error("divider busy outside divide state");

   a_mac_in_mat_state: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (state_ff == S_MAT))
      else $error("accumulate stage active outside matrix pass");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised without a finished edge");

endmodule

// ===== tb/wep_checker.sv =====
// Line checker for the wireframe edge projector: mirrors the matrices, points and
// window registers, predicts each drawn line and compares it. Depends on wep_pkg.
module wep_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_first_index,
   input  logic [5:0]         req_second_index,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   input  logic [31:0]        req_edge_color,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_start_x,
   input  logic signed [31:0] rsp_start_y,
   input  logic signed [31:0] rsp_end_x,
   input  logic signed [31:0] rsp_end_y,
   input  logic [31:0]        rsp_line_color,
   input  logic [16:0]        rsp_line_thickness,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wr_data,
   output int                 fail_count,
   output int                 lines_pending
);
   import wep_pkg::*;

   typedef struct packed {
      logic signed [31:0] sx, sy, ex, ey;
      logic [31:0]        color;
      logic [16:0]        thick;
   } line_type;

   logic signed [31:0] vp_mat [16];
   logic signed [31:0] mt_mat [12];
   logic signed [31:0] pts [64][3];
   logic [13:0] win_w, win_h;
   logic [15:0] thick_mul;
   line_type expected_lines [$];

   assign lines_pending = expected_lines.size();

   function automatic longint floor16(longint v);
      return v >>> 16;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] mat_row(logic signed [31:0] m [], int r,
                                                  logic signed [31:0] a, b, c);
      longint acc;
      acc = m[r*4+3];
      acc += floor16(longint'(m[r*4]) * a);
      acc += floor16(longint'(m[r*4+1]) * b);
      acc += floor16(longint'(m[r*4+2]) * c);
      return clamp32(acc);
   endfunction

   function automatic logic signed [31:0] persp_div(logic signed [31:0] n, w);
      if (w == 0) return (n > 0) ? 32'sh7FFF_FFFF : (n < 0) ? 32'sh8000_0000 : 0;
      return clamp32((longint'(n) * 65536) / longint'(w));
   endfunction

   function automatic logic signed [31:0] scale_px(longint ndc, logic [13:0] size);
      return clamp32(((ndc + 65536) * longint'({50'd0, size})) >>> 1);
   endfunction

   // returns 0 when the point is behind the camera
   function automatic bit project_pt(int idx, output logic signed [31:0] x, y);
      logic signed [31:0] c [4];
      logic signed [31:0] vp [];
      vp = new[16];
      foreach (vp_mat[i]) vp[i] = vp_mat[i];
      for (int r = 0; r < 4; r++) c[r] = mat_row(vp, r, pts[idx][0], pts[idx][1], pts[idx][2]);
      if (c[2] < 0) return 0;
      x = scale_px(longint'(persp_div(c[0], c[3])), win_w);
      y = scale_px(-longint'(persp_div(c[1], c[3])), win_h);
      return 1;
   endfunction

   function automatic void compare_field(string name, logic [31:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      logic signed [31:0] sx, sy, ex, ey;
      logic signed [31:0] mt [];
      line_type ln;
      if (reset) begin
         foreach (vp_mat[i]) vp_mat[i] = 0;
         foreach (mt_mat[i]) mt_mat[i] = 0;
         mt_mat[0] = ONE_Q16; mt_mat[5] = ONE_Q16; mt_mat[10] = ONE_Q16;
         win_w = WIDTH_RST; win_h = HEIGHT_RST; thick_mul = THICK_RST;
         fail_count = 0;
         expected_lines.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_type'(csr_index))
               CSR_WIDTH:  win_w = csr_wr_data[13:0];
               CSR_HEIGHT: win_h = csr_wr_data[13:0];
               CSR_THICK:  thick_mul = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected line transfer");
            end else begin
               ln = expected_lines.pop_front();
               compare_field("start_x", ln.sx, rsp_start_x);
               compare_field("start_y", ln.sy, rsp_start_y);
               compare_field("end_x", ln.ex, rsp_end_x);
               compare_field("end_y", ln.ey, rsp_end_y);
               compare_field("line_color", ln.color, rsp_line_color);
               compare_field("line_thickness", {15'd0, ln.thick}, {15'd0, rsp_line_thickness});
            end
         end
         if (req_valid && !req_stall) begin
            case (op_type'(req_op))
               OP_LOAD_VP: if (req_first_index < 16) vp_mat[req_first_index] = req_value_x;
               OP_LOAD_MT: if (req_first_index < 12) mt_mat[req_first_index] = req_value_x;
               OP_LOAD_PT: begin
                  mt = new[12];
                  foreach (mt_mat[i]) mt[i] = mt_mat[i];
                  for (int r = 0; r < 3; r++)
                     pts[req_first_index][r] =
                        mat_row(mt, r, req_value_x, req_value_y, req_value_z);
               end
               OP_EDGE: begin
                  if (project_pt(req_first_index, sx, sy) &&
                      project_pt(req_second_index, ex, ey)) begin
                     ln.sx = sx; ln.sy = sy; ln.ex = ex; ln.ey = ey;
                     ln.color = req_edge_color;
                     ln.thick = {thick_mul, 1'b0};
                     expected_lines = {expected_lines, ln};
                  end
               end
               default: ;
            endcase
         end
      end
   end
endmodule

// ===== tb/wireframe_edge_projector_tb.sv =====
// Stimulus and verdict for the wireframe edge projector: loads matrices and points,
// draws edges under random gaps and stalls. Depends on wep_pkg, wep_checker and the RTL.
module wireframe_edge_projector_tb;
   import wep_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_op;
   logic [5:0] req_first_index, req_second_index;
   logic signed [31:0] req_value_x, req_value_y, req_value_z;
   logic [31:0] req_edge_color;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic [31:0] rsp_line_color;
   logic [16:0] rsp_line_thickness;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [15:0] csr_wr_data;
   int fail_count, lines_pending;
   bit written [64];
   bit stall_random;

   wireframe_edge_projector uut (.*);

   wep_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("wireframe_edge_projector_tb: errors");
      $finish;
   end

   // receiver: when stall_random is set, may hold off each offered line with rsp_stall
   initial begin
      int hold;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (rsp_valid && stall_random) begin
            hold = $urandom_range(0, 7);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
               rsp_stall <= 1'b0;
            end
            @(posedge clock);
         end
      end
   end

   // returns at the accepting edge; valid stays up when the next item has no gap
   task automatic send(op_type op, logic [5:0] a, b, logic [31:0] x, y, z, color);
      int gap;
      gap = $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1; req_op <= op; req_first_index <= a; req_second_index <= b;
      req_value_x <= x; req_value_y <= y; req_value_z <= z; req_edge_color <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD_PT && a < 64) written[a] = 1;
   endtask

   task automatic write_reg(csr_type idx, logic [15:0] data);
      @(negedge clock);
      req_valid <= 0;
      csr_wr_en <= 1; csr_index <= idx; csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 0;
      while (lines_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_q16();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
      endcase
   endfunction

   function automatic logic [5:0] pick_pt();
      logic [5:0] p;
      do p = 6'($urandom_range(0, 63)); while (!written[p]);
      return p;
   endfunction

   // a sane camera: w = 1 + z/4, clip z = z, small scale on x and y
   task automatic load_camera();
      logic [31:0] m [16];
      foreach (m[i]) m[i] = 0;
      m[0] = 32'h10000 + ($urandom_range(0, 'h8000));
      m[5] = 32'h10000 + ($urandom_range(0, 'h8000));
      m[10] = 32'h10000; m[14] = 32'h4000; m[15] = 32'h10000;
      m[3] = $urandom_range(0, 'h4000);
      for (int i = 0; i < 16; i++) send(OP_LOAD_VP, 6'(i), 0, m[i], 0, 0, 0);
   endtask

   initial begin
      int n;
      logic [5:0] a;
      req_valid = 0; req_op = 0; req_first_index = 0; req_second_index = 0;
      req_value_x = 0; req_value_y = 0; req_value_z = 0; req_edge_color = 0;
      csr_wr_en = 0; csr_index = 0; csr_wr_data = 0; stall_random = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero matrix gives w = 0 for every point
      send(OP_LOAD_PT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send(OP_LOAD_PT, 63, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
      send(OP_EDGE, 0, 63, 0, 0, 0, 32'hFFFF_FFFF);
      send(OP_LOAD_VP, 16, 0, 32'h1234, 0, 0, 0);
      send(OP_LOAD_MT, 12, 0, 32'h1234, 0, 0, 0);
      send(OP_LOAD_MT, 11, 0, 32'hFFFF_0000, 0, 0, 0);
      send(OP_LOAD_PT, 1, 0, 32'h20000, 32'h10000, 32'h30000, 0);
      send(OP_EDGE, 1, 0, 0, 0, 0, 32'h00FF_00FF);
      load_camera();
      send(OP_EDGE, 1, 1, 0, 0, 0, 32'hA5A5_5A5A);
      send(OP_EDGE, 0, 1, 0, 0, 0, 32'h1);
      send(OP_EDGE, 63, 1, 0, 0, 0, 32'h2);
      drain();
      write_reg(CSR_WIDTH, 16'h3FFF);
      write_reg(CSR_HEIGHT, 16'hFFFF);
      write_reg(CSR_THICK, 16'hFFFF);
      send(OP_EDGE, 1, 0, 0, 0, 0, 32'h3);
      drain();
      write_reg(CSR_WIDTH, 0);
      write_reg(CSR_HEIGHT, 1);
      write_reg(CSR_THICK, 0);
      send(OP_EDGE, 1, 1, 0, 0, 0, 32'h4);
      drain();

      // random phases, each with fresh registers and model transform
      n = 0;
      for (int ph = 0; n < 1550; ph++) begin
         write_reg(CSR_WIDTH, (ph % 3 == 0) ? 16'd1 : 16'($urandom_range(1, 8192)));
         write_reg(CSR_HEIGHT, (ph % 3 == 1) ? 16'd8192 : 16'($urandom_range(1, 8192)));
         write_reg(CSR_THICK, 16'($urandom()));
         stall_random = ph % 4 != 3;
         for (int i = 0; i < 12; i++) begin
            send(OP_LOAD_MT, 6'(i), 0, (i % 5 == 0) ? 32'h10000 + $urandom_range(0, 'h4000)
                 : $urandom_range(0, 'h3000), 0, 0, 0);
            n++;
         end
         if ($urandom_range(0, 2) == 0) begin
            load_camera();
            n += 16;
         end
         for (int k = 0; k < 100; k++) begin
            case ($urandom_range(0, 9))
               0: send(OP_LOAD_PT, 6'($urandom()), 0, rnd_q16(), rnd_q16(), rnd_q16(), 0);
               1: send(OP_LOAD_PT, 6'($urandom()), 0, $urandom_range(0, 'h40000),
                       $urandom_range(0, 'h40000), $urandom_range(0, 'h80000), 0);
               2: send(OP_LOAD_VP, 6'($urandom()), 0, rnd_q16(), 0, 0, 0);
               3: send(OP_LOAD_MT, 6'($urandom()), 0, rnd_q16(), 0, 0, 0);
               default: begin
                  a = pick_pt();
                  send(OP_EDGE, a, pick_pt(), $urandom(), $urandom(), $urandom(), $urandom());
               end
            endcase
            n++;
         end
         drain();
      end
      drain();
      if (fail_count == 0)
         $display("wireframe_edge_projector_tb: clean");
      else
         $display("wireframe_edge_projector_tb: errors");
      $finish;
   end
endmodule
